// ----- rtl/etrb_pkg.sv -----
// Shared types and constants for the event trace ring buffer.
`default_nettype none

package etrb_pkg;

  // Width of the drain limit field and of the burst counter
  localparam int LIM_W = 7;

  // Most events one drain transaction may emit
  localparam logic [LIM_W-1:0] MAX_BURST = 7'd64;

  // Operation codes
  typedef enum logic {
    FN_RECORD = 1'b0,
    FN_DRAIN  = 1'b1
  } func_t;

  // Drain sequencer states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // Input transaction
  typedef struct packed {
    func_t              func;
    logic [7:0]         event_kind;
    logic signed [63:0] detail_first;
    logic signed [63:0] detail_second;
    logic [62:0]        time_nanos;
    logic [LIM_W-1:0]   drain_limit;
  } req_t;

  // Output transaction
  typedef struct packed {
    logic [7:0]         out_kind;
    logic [31:0]        out_sequence;
    logic [62:0]        out_time;
    logic signed [63:0] out_detail_first;
    logic signed [63:0] out_detail_second;
    logic               empty_flag;
    logic               last_flag;
    logic [31:0]        drop_total;
  } rsp_t;

  // One stored event in the ring memory
  typedef struct packed {
    logic [7:0]         kind;
    logic [31:0]        sequence_num;
    logic [62:0]        time_nanos;
    logic signed [63:0] detail_first;
    logic signed [63:0] detail_second;
  } entry_t;

endpackage : etrb_pkg

`default_nettype wire

// ----- rtl/event_trace_ring_buffer_top.sv -----
// Top level of the event trace ring buffer: pointers, counters, drain sequencer, output queue.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_t (record or drain)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_t (event, empty or last marker)
//
// A record transaction is taken every cycle while idle and written to the ring memory at once if not full.
// After a drain transaction is accepted, one stored event per cycle while the queue has room
// leaves the memory's single read port, each arriving in the cycle after its read.
// Reset clears the pointers and counters; the ring memory is not cleared.
// A two-entry output queue absorbs rsp_stall; reads are issued only when it has room.
// Further transactions wait while a drain is in progress.
`default_nettype none

module event_trace_ring_buffer_top
  import etrb_pkg::*;
#(
  parameter int RING_DEPTH = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int LW = (PW > LIM_W) ? PW : LIM_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(RING_DEPTH);
  localparam logic [PW-1:0] PTR_MAX = PW'(2 * RING_DEPTH - 1);
  localparam logic [PW:0]   SPAN    = (PW + 1)'(2 * RING_DEPTH);

  // Map a pointer that runs modulo twice the depth onto a slot
  function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? (p - DEPTH_P) : p;
    return s[AW-1:0];
  endfunction

  // Advance a pointer, wrapping at twice the depth
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_MAX) ? '0 : (p + 1'b1);
  endfunction

  logic [PW-1:0]    write_pointer, write_pointer_next;
  logic [PW-1:0]    read_pointer, read_pointer_next;
  logic [31:0]      sequence_counter, sequence_counter_next;
  logic [31:0]      drop_counter, drop_counter_next;
  logic [LIM_W-1:0] remaining, remaining_next;
  state_t           state, state_next;

  // Read in flight and what travels with it
  logic             rd_pending, rd_pending_next;
  logic             rd_last;
  logic [31:0]      rd_drops;

  // Output queue
  rsp_t             obuf [2];
  logic             ohead;
  logic [1:0]       ocount;

  logic [PW:0]      occ_wide;
  logic [PW-1:0]    occupancy;
  logic [LW-1:0]    occ_cmp, lim_cmp;
  logic [LIM_W-1:0] limit, burst;
  logic             full;
  logic             req_acc, rec_acc, drn_acc, rsp_pop;
  logic [1:0]       slots;
  logic             issue, issue_last;
  logic             push;
  rsp_t             push_data;
  entry_t           wr_entry, rd_entry;

  // Occupancy and drain burst length
  assign occ_wide  = {1'b0, write_pointer} + SPAN - {1'b0, read_pointer};
  assign occupancy = (write_pointer >= read_pointer) ? (write_pointer - read_pointer)
                                                     : occ_wide[PW-1:0];
  assign full      = (occupancy == DEPTH_P);
  assign limit     = (req.drain_limit > MAX_BURST) ? MAX_BURST : req.drain_limit;
  assign occ_cmp   = LW'(occupancy);
  assign lim_cmp   = LW'(limit);
  assign burst     = (occ_cmp < lim_cmp) ? occ_cmp[LIM_W-1:0] : limit;

  // Handshakes
  assign rsp_valid = (ocount != 2'd0);
  assign rsp       = obuf[ohead];
  assign rsp_pop   = rsp_valid && !rsp_stall;
  assign req_stall = (state != ST_IDLE)
                  || ((req.func == FN_DRAIN) && (rd_pending || (ocount == 2'd2)));
  assign req_acc   = req_valid && !req_stall;
  assign rec_acc   = req_acc && (req.func == FN_RECORD);
  assign drn_acc   = req_acc && (req.func == FN_DRAIN);

  // Output queue room including the read in flight
  assign slots = ocount + {1'b0, rd_pending};

  // Sequencer, pointers and counters
  always_comb begin
    state_next            = state;
    remaining_next        = remaining;
    write_pointer_next    = write_pointer;
    read_pointer_next     = read_pointer;
    sequence_counter_next = sequence_counter;
    drop_counter_next     = drop_counter;
    issue                 = 1'b0;
    issue_last            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (rec_acc) begin
          if (full) begin
            if (drop_counter != '1) begin
              drop_counter_next = drop_counter + 32'd1;
            end
          end else begin
            sequence_counter_next = sequence_counter + 32'd1;
            write_pointer_next    = ptr_inc(write_pointer);
          end
        end
        if (drn_acc && (burst != '0)) begin
          remaining_next = burst;
          state_next     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if ((slots < 2'd2) || ((slots == 2'd2) && rsp_pop)) begin
          issue             = 1'b1;
          issue_last        = (remaining == LIM_W'(1));
          remaining_next    = remaining - 1'b1;
          read_pointer_next = ptr_inc(read_pointer);
          if (issue_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_pending_next = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      write_pointer    <= '0;
      read_pointer     <= '0;
      sequence_counter <= '0;
      drop_counter     <= '0;
      remaining        <= '0;
      rd_pending       <= 1'b0;
    end else begin
      state            <= state_next;
      write_pointer    <= write_pointer_next;
      read_pointer     <= read_pointer_next;
      sequence_counter <= sequence_counter_next;
      drop_counter     <= drop_counter_next;
      remaining        <= remaining_next;
      rd_pending       <= rd_pending_next;
    end
  end

  // Carry the last marker and drop count alongside the read
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last  <= issue_last;
      rd_drops <= drop_counter;
    end
  end

  // Ring memory
  assign wr_entry.kind          = req.event_kind;
  assign wr_entry.sequence_num  = sequence_counter + 32'd1;
  assign wr_entry.time_nanos    = req.time_nanos;
  assign wr_entry.detail_first  = req.detail_first;
  assign wr_entry.detail_second = req.detail_second;

  etrb_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (rec_acc && !full),
    .wr_addr (slot_of(write_pointer)),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (slot_of(read_pointer)),
    .rd_data (rd_entry)
  );

  // Select what enters the output queue: returning event or empty marker
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (rd_pending) begin
      push                        = 1'b1;
      push_data.out_kind          = rd_entry.kind;
      push_data.out_sequence      = rd_entry.sequence_num;
      push_data.out_time          = rd_entry.time_nanos;
      push_data.out_detail_first  = rd_entry.detail_first;
      push_data.out_detail_second = rd_entry.detail_second;
      push_data.last_flag         = rd_last;
      push_data.drop_total        = rd_drops;
    end else if (drn_acc && (burst == '0)) begin
      push                 = 1'b1;
      push_data.empty_flag = 1'b1;
      push_data.drop_total = drop_counter;
    end
  end

  // Output queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      ohead  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (rsp_pop) begin
        ohead <= ~ohead;
      end
      ocount <= ocount + {1'b0, push} - {1'b0, rsp_pop};
    end
  end

  // Output queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      obuf[ohead ^ ocount[0]] <= push_data;
    end
  end

endmodule : event_trace_ring_buffer_top

`default_nettype wire

// ----- rtl/etrb_ram.sv -----
// Simple dual-port ring memory with registered read.
`default_nettype none

module etrb_ram
  import etrb_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : etrb_ram

`default_nettype wire
